[hw/rtl/mck_pkg.sv]
package mck_pkg;

   localparam int ACC_W = 39;
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   localparam logic [1:0] CSR_SCALE_FACTOR = 2'd0;
   localparam logic [1:0] CSR_VARIANCE     = 2'd1;

   localparam logic [23:0] SCALE_RESET    = 24'd113512;
   localparam logic [31:0] VARIANCE_RESET = 32'd65536;

   typedef enum logic [3:0] {
      OP_NONE, OP_SQRT, OP_RMUL, OP_RQ, OP_DIV, OP_GSET, OP_TMUL, OP_TDIV,
      OP_TSUB, OP_SQM, OP_SQA, OP_SHF, OP_KMUL, OP_KSET, OP_CMUL, OP_LOAD
   } op_type;

   typedef struct packed {
      logic       accum;
      op_type     op;
      logic [4:0] cnt;
   } cmd_type;

   typedef struct packed {
      logic k_zero;
   } sts_type;

   // ceil(2^32 / j) for j = 2..6; floor(p * R >> 32) == p / j for p < 2^27
   function automatic logic [31:0] recip(input logic [2:0] j);
      logic [31:0] r;
      case (j)
         3'd2:    r = 32'd2147483648;
         3'd3:    r = 32'd1431655766;
         3'd4:    r = 32'd1073741824;
         3'd5:    r = 32'd858993460;
         3'd6:    r = 32'd715827883;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/mck_ctrl.sv]
module mck_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  mck_pkg::sts_type sts,
   output mck_pkg::cmd_type cmd
);
   import mck_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE = 16'h0001, S_SQRT = 16'h0002, S_RMUL = 16'h0004, S_RQ   = 16'h0008,
      S_DIV  = 16'h0010, S_GSET = 16'h0020, S_TMUL = 16'h0040, S_TDIV = 16'h0080,
      S_TSUB = 16'h0100, S_SQM  = 16'h0200, S_SQA  = 16'h0400, S_SHF  = 16'h0800,
      S_KMUL = 16'h1000, S_KSET = 16'h2000, S_CMUL = 16'h4000, S_FIN  = 16'h8000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       vld_ff, vld_in;
   logic       fire, load;

   assign req_ready = (state_ff == S_IDLE);
   assign fire      = req_valid && req_ready;
   assign load      = (state_ff == S_FIN) && (!vld_ff || rsp_ready);
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd.accum = fire;
      cmd.cnt   = cnt_ff;
      cmd.op    = OP_NONE;
      vld_in    = load ? 1'b1 : (rsp_ready ? 1'b0 : vld_ff);
      case (state_ff)
         S_IDLE: begin
            if (fire && req_last) begin
               state_in = S_SQRT;
               cnt_in   = 5'd27;
            end
         end
         S_SQRT: begin
            cmd.op = OP_SQRT;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) state_in = S_RMUL;
         end
         S_RMUL: begin
            cmd.op   = OP_RMUL;
            state_in = S_RQ;
         end
         S_RQ: begin
            cmd.op = OP_RQ;
            cnt_in = 5'd5;
            state_in = sts.k_zero ? S_CMUL : S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) state_in = S_GSET;
         end
         S_GSET: begin
            cmd.op   = OP_GSET;
            cnt_in   = 5'd6;
            state_in = S_TMUL;
         end
         S_TMUL: begin
            cmd.op   = OP_TMUL;
            state_in = S_TDIV;
         end
         S_TDIV: begin
            cmd.op   = OP_TDIV;
            state_in = S_TSUB;
         end
         S_TSUB: begin
            cmd.op = OP_TSUB;
            if (cnt_ff == 5'd1) begin
               state_in = S_SQM;
               cnt_in   = 5'd2;
            end else begin
               state_in = S_TMUL;
               cnt_in   = cnt_ff - 5'd1;
            end
         end
         S_SQM: begin
            cmd.op   = OP_SQM;
            state_in = S_SQA;
         end
         S_SQA: begin
            cmd.op = OP_SQA;
            cnt_in = cnt_ff - 5'd1;
            state_in = (cnt_ff == 5'd0) ? S_SHF : S_SQM;
         end
         S_SHF: begin
            cmd.op   = OP_SHF;
            state_in = S_KMUL;
         end
         S_KMUL: begin
            cmd.op   = OP_KMUL;
            state_in = S_KSET;
         end
         S_KSET: begin
            cmd.op   = OP_KSET;
            state_in = S_CMUL;
         end
         S_CMUL: begin
            cmd.op   = OP_CMUL;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (load) begin
               cmd.op   = OP_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 5'd0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

endmodule

[hw/rtl/mck_dpath.sv]
module mck_dpath (
   input  logic               clock,
   input  logic               reset,
   input  mck_pkg::cmd_type   cmd,
   output mck_pkg::sts_type   sts,
   input  logic signed [15:0] req_coord_a,
   input  logic signed [15:0] req_coord_b,
   input  logic               req_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output logic [31:0]        rsp_covariance,
   output logic               rsp_overflow
);
   import mck_pkg::*;

   logic [ACC_W-1:0] acc_ff;
   logic             sat_ff, hold_ff;
   logic [23:0]      scale_ff;
   logic [31:0]      var_ff;
   logic [55:0]      rad_ff;
   logic [30:0]      rem_ff;
   logic [27:0]      root_ff;
   logic [63:0]      prod_ff;
   logic [20:0]      rq_ff;
   logic [34:0]      xr_ff;
   logic [5:0]       n_ff;
   logic [26:0]      g_ff, p_ff;
   logic [30:0]      t_ff, k_ff;
   logic [31:0]      cov_ff;
   logic             ovf_ff;

   logic signed [16:0] diff;
   logic [15:0]        mag;
   logic [31:0]        sq;
   logic [ACC_W:0]     sum;
   logic               over;
   logic [ACC_W-1:0]   sum_sat;
   logic [30:0]        rem_t, trial;
   logic               ge;
   logic [52:0]        rq_sum;
   logic [34:0]        sub;
   logic [31:0]        mul_a, mul_b;
   logic               mul_en;
   logic [30:0]        g_sum;
   logic [26:0]        q;
   logic [60:0]        sq_rnd;
   logic [21:0]        kfac;
   logic [62:0]        cov_rnd;

   // accumulate one squared coordinate difference, saturating
   assign diff    = 17'(req_coord_a) - 17'(req_coord_b);
   assign mag     = diff[16] ? 16'(-diff) : diff[15:0];
   assign sq      = mag * mag;
   assign sum     = {1'b0, acc_ff} + {8'b0, sq};
   assign over    = sum[ACC_W];
   assign sum_sat = over ? ACC_MAX : sum[ACC_W-1:0];

   // one root bit per cycle
   assign rem_t = {rem_ff[28:0], rad_ff[55:54]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign ge    = rem_t >= trial;

   assign rq_sum     = {1'b0, prod_ff[51:0]} + 53'h8000;
   assign sts.k_zero = |rq_sum[52:37];
   assign sub        = {5'b0, LN2_Q30} << cmd.cnt[2:0];
   assign g_sum      = {1'b0, xr_ff[29:0]} + 31'd4;
   assign q          = (cmd.cnt == 5'd1) ? p_ff : prod_ff[58:32];
   assign sq_rnd     = prod_ff[60:0] + 61'h2000_0000;
   assign kfac       = 22'h10000 + {1'b0, rq_ff};
   assign cov_rnd    = prod_ff[62:0] + 63'h2000_0000;

   // shared 32x32 multiplier, product registered
   always_comb begin
      mul_en = 1'b1;
      mul_a  = 32'd0;
      mul_b  = 32'd0;
      case (cmd.op)
         OP_RMUL: begin mul_a = {4'b0, root_ff};  mul_b = {8'b0, scale_ff}; end
         OP_TMUL: begin mul_a = {5'b0, g_ff};     mul_b = {1'b0, t_ff};     end
         OP_TDIV: begin mul_a = {5'b0, prod_ff[56:30]}; mul_b = recip(cmd.cnt[2:0]); end
         OP_SQM:  begin mul_a = {1'b0, t_ff};     mul_b = {1'b0, t_ff};     end
         OP_KMUL: begin mul_a = {10'b0, kfac};    mul_b = {1'b0, t_ff};     end
         OP_CMUL: begin mul_a = var_ff;           mul_b = {1'b0, k_ff};     end
         default: mul_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         sat_ff   <= 1'b0;
         scale_ff <= SCALE_RESET;
         var_ff   <= VARIANCE_RESET;
      end else begin
         if (csr_we && csr_index == CSR_SCALE_FACTOR) scale_ff <= csr_wdata[23:0];
         if (csr_we && csr_index == CSR_VARIANCE)     var_ff   <= csr_wdata;
         if (cmd.accum) begin
            if (req_last) begin
               acc_ff <= '0;
               sat_ff <= 1'b0;
            end else begin
               acc_ff <= sum_sat;
               sat_ff <= sat_ff | over;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accum && req_last) begin
         rad_ff  <= {1'b0, sum_sat, 16'b0};
         rem_ff  <= '0;
         root_ff <= '0;
         hold_ff <= sat_ff | over;
      end
      if (mul_en) prod_ff <= mul_a * mul_b;
      case (cmd.op)
         OP_SQRT: begin
            rad_ff  <= {rad_ff[53:0], 2'b00};
            rem_ff  <= ge ? rem_t - trial : rem_t;
            root_ff <= {root_ff[26:0], ge};
         end
         OP_RQ: begin
            rq_ff <= rq_sum[36:16];
            xr_ff <= {rq_sum[36:16], 14'b0};
            n_ff  <= '0;
            k_ff  <= '0;
         end
         OP_DIV: begin
            if (xr_ff >= sub) begin
               xr_ff               <= xr_ff - sub;
               n_ff[cmd.cnt[2:0]] <= 1'b1;
            end
         end
         OP_GSET: begin
            g_ff <= g_sum[29:3];
            t_ff <= Q30_ONE;
         end
         OP_TDIV: p_ff <= prod_ff[56:30];
         OP_TSUB: t_ff <= Q30_ONE - {4'b0, q};
         OP_SQA:  t_ff <= sq_rnd[60:30];
         OP_SHF:  t_ff <= t_ff >> n_ff;
         OP_KSET: k_ff <= (prod_ff[52:16] > {6'b0, Q30_ONE}) ? Q30_ONE : prod_ff[46:16];
         OP_LOAD: begin
            cov_ff <= cov_rnd[61:30];
            ovf_ff <= hold_ff;
         end
         default: ;
      endcase
   end

   assign rsp_covariance = cov_ff;
   assign rsp_overflow   = ovf_ff;

endmodule

[hw/rtl/matern32_covariance_kernel_core.sv]
// Matern 3/2 covariance kernel core.
// Throughput: items not marked last are taken one per cycle while no evaluation is in progress.
// rsp_valid rises after an item marked last is taken and its evaluation has run: the bit-serial square root
// and the shared multiplier sequence (cut short to the final scale multiply when exp underflows).
// Input is held off during that evaluation; a waiting result does not stall accumulation.
// Reset (synchronous): clears accumulator, flag, sequencer; CSR registers take their defaults.
module matern32_covariance_kernel_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_coord_a,
   input  logic signed [15:0] req_coord_b,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_covariance,
   output logic               rsp_overflow,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import mck_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: accumulate, root, r, range reduction, series, squarings, scale
   mck_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic, one shared multiplier, result register on the response side
   mck_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_coord_a    (req_coord_a),
      .req_coord_b    (req_coord_b),
      .req_last       (req_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_covariance (rsp_covariance),
      .rsp_overflow   (rsp_overflow)
   );

endmodule
